// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LCRV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LCRV_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCRV_ASSERT(lbl, clk, rstn, prop, msg)
`define LCRV_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/lcrv_pkg.sv =====
// Types and constants of the LC resonance value calculator
package lcrv_pkg;
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned FREQ_W  = 23;
  localparam int unsigned BASE_W  = 20;
  localparam int unsigned REFC_W  = 20;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SCL_W   = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 23;

  localparam logic [OPC_W-1:0] OP_BASE = 2'd0;
  localparam logic [OPC_W-1:0] OP_REF  = 2'd1;
  localparam logic [OPC_W-1:0] OP_CAP  = 2'd2;
  localparam logic [OPC_W-1:0] OP_IND  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ABOVE  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_LOW    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_UNCAL  = 3'd4;

  localparam logic [SCL_W-1:0] SCL_10FF = 2'd0;
  localparam logic [SCL_W-1:0] SCL_01PF = 2'd1;
  localparam logic [SCL_W-1:0] SCL_NH   = 2'd2;
  localparam logic [SCL_W-1:0] SCL_UH   = 2'd3;

  localparam logic [CIDX_W-1:0] REG_REF_CAP  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_BASE_MIN = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BASE_MAX = 3'd2;
  localparam logic [CIDX_W-1:0] REG_REF_MIN  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_REF_MAX  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_MEAS_MIN = 3'd5;

  localparam logic [63:0]  PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [127:0] PI_SQ_FULL  = {64'd0, PI_Q60} * {64'd0, PI_Q60};
  localparam logic [63:0]  PI_SQ_Q60   = PI_SQ_FULL[123:60];

  typedef enum logic [1:0] {UOP_END, UOP_DIV, UOP_MUL} uop_kind_e;
  typedef enum logic [3:0] {
    SRC_T, SRC_U, SRC_X, SRC_IFB, SRC_IF, SRC_I1, SRC_I10, SRC_I1K, SRC_I10K,
    SRC_I100K, SRC_I1M, SRC_IREF, SRC_ITANK, SRC_FPS
  } uop_src_e;
  typedef enum logic [1:0] {DST_T, DST_U, DST_X} uop_dst_e;
  typedef enum logic [1:0] {POST_NONE, POST_SUB1, POST_SUBU} uop_post_e;
  typedef enum logic [1:0] {COND_NONE, COND_LT10K, COND_LT1K} uop_cond_e;

  typedef struct packed {
    uop_kind_e kind;
    uop_src_e  sa;
    uop_src_e  sb;
    uop_dst_e  dst;
    uop_post_e post;
    uop_cond_e cond;
  } uop_t;

  localparam int unsigned PC_W = 5;
  localparam logic [PC_W-1:0] PC_REF = 5'd0;
  localparam logic [PC_W-1:0] PC_CAP = 5'd4;
  localparam logic [PC_W-1:0] PC_IND = 5'd9;

  function automatic uop_t mk(input uop_kind_e k, input uop_src_e a, input uop_src_e b,
                              input uop_dst_e d, input uop_post_e p, input uop_cond_e c);
    uop_t u;
    u.kind = k; u.sa = a; u.sb = b; u.dst = d; u.post = p; u.cond = c;
    return u;
  endfunction

  // step programs: reference from 0, capacitor from 4, inductor from 9
  function automatic uop_t decode(input logic [PC_W-1:0] pc);
    uop_t u;
    u = mk(UOP_END, SRC_T, SRC_T, DST_T, POST_NONE, COND_NONE);
    unique case (pc)
      5'd0:  u = mk(UOP_DIV, SRC_IFB, SRC_IF, DST_T, POST_NONE, COND_NONE);
      5'd1:  u = mk(UOP_MUL, SRC_T, SRC_T, DST_T, POST_SUB1, COND_NONE);
      5'd2:  u = mk(UOP_DIV, SRC_IREF, SRC_T, DST_X, POST_NONE, COND_NONE);
      5'd4:  u = mk(UOP_DIV, SRC_IFB, SRC_IF, DST_T, POST_NONE, COND_NONE);
      5'd5:  u = mk(UOP_MUL, SRC_T, SRC_T, DST_T, POST_SUB1, COND_NONE);
      5'd6:  u = mk(UOP_MUL, SRC_ITANK, SRC_T, DST_X, POST_NONE, COND_NONE);
      5'd7:  u = mk(UOP_MUL, SRC_X, SRC_I10, DST_X, POST_NONE, COND_LT10K);
      5'd9:  u = mk(UOP_DIV, SRC_IF, SRC_I10K, DST_T, POST_NONE, COND_NONE);
      5'd10: u = mk(UOP_MUL, SRC_T, SRC_T, DST_T, POST_NONE, COND_NONE);
      5'd11: u = mk(UOP_DIV, SRC_I1, SRC_T, DST_U, POST_NONE, COND_NONE);
      5'd12: u = mk(UOP_DIV, SRC_IFB, SRC_I10K, DST_T, POST_NONE, COND_NONE);
      5'd13: u = mk(UOP_MUL, SRC_T, SRC_T, DST_T, POST_NONE, COND_NONE);
      5'd14: u = mk(UOP_DIV, SRC_I1, SRC_T, DST_T, POST_SUBU, COND_NONE);
      5'd15: u = mk(UOP_MUL, SRC_FPS, SRC_ITANK, DST_X, POST_NONE, COND_NONE);
      5'd16: u = mk(UOP_DIV, SRC_X, SRC_I100K, DST_X, POST_NONE, COND_NONE);
      5'd17: u = mk(UOP_DIV, SRC_I1, SRC_X, DST_X, POST_NONE, COND_NONE);
      5'd18: u = mk(UOP_MUL, SRC_X, SRC_I1M, DST_X, POST_NONE, COND_NONE);
      5'd19: u = mk(UOP_MUL, SRC_X, SRC_T, DST_X, POST_NONE, COND_NONE);
      5'd20: u = mk(UOP_MUL, SRC_X, SRC_I1K, DST_X, POST_NONE, COND_LT1K);
      default: u = mk(UOP_END, SRC_T, SRC_T, DST_T, POST_NONE, COND_NONE);
    endcase
    return u;
  endfunction
endpackage

// ===== hw/rtl/lcrv_if.sv =====
// Handshake channel interfaces: input item, result item, register write
interface lcrv_in_if;
  logic                         valid;
  logic                         ready;
  logic [lcrv_pkg::OPC_W-1:0]   opcode;
  logic [lcrv_pkg::FREQ_W-1:0]  freq;
  modport source (output valid, output opcode, output freq, input ready);
  modport sink (input valid, input opcode, input freq, output ready);
endinterface

interface lcrv_res_if;
  logic                         valid;
  logic                         ready;
  logic [lcrv_pkg::VAL_W-1:0]   value;
  logic [lcrv_pkg::SCL_W-1:0]   scale_code;
  logic [lcrv_pkg::STAT_W-1:0]  status;
  modport source (output valid, output value, output scale_code, output status, input ready);
  modport sink (input valid, input value, input scale_code, input status, output ready);
endinterface

interface lcrv_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lcrv_pkg::CIDX_W-1:0]  index;
  logic [lcrv_pkg::CDAT_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/lc_resonance_value_calculator_core.sv =====
// Top level: LC meter value calculator with shared serial divider and multiplier
// Items that only carry a status go straight to the finish state; reference, capacitor
// and inductor items run their step program between accept and the result beat.
// Throughput: one item at a time; the 1 bit/cycle divider dominates.
// Reset: async active low; config registers to defaults, base and calibration cleared.
`include "assert_macros.svh"
module lc_resonance_value_calculator_core #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lcrv_in_if.sink      in_i,
  lcrv_res_if.source   res_o,
  lcrv_cfg_if.sink     cfg_i
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [63:0] FX_MAX = '1;
  localparam logic [63:0] ONE    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF   = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] FPS    = lcrv_pkg::PI_SQ_Q60 >> (58 - FRAC_BITS);
  localparam logic [63:0] LIM10K = 64'd10000 << FRAC_BITS;
  localparam logic [63:0] LIM1K  = 64'd1000 << FRAC_BITS;

  function automatic logic [63:0] fx_int(input logic [31:0] n);
    return {32'd0, n} << FRAC_BITS;
  endfunction

  logic [2:0]                    st_q, st_d;
  logic [lcrv_pkg::PC_W-1:0]     pc_q, pc_d;
  logic [5:0]                    cnt_q, cnt_d;
  logic [lcrv_pkg::OPC_W-1:0]    op_q, op_d;
  logic [lcrv_pkg::FREQ_W-1:0]   f_q, f_d;
  logic [lcrv_pkg::STAT_W-1:0]   stat_q, stat_d;
  logic                          small_q, small_d;
  logic [lcrv_pkg::REFC_W-1:0]   refc_q, refc_d;
  logic [lcrv_pkg::FREQ_W-1:0]   bmin_q, bmin_d, bmax_q, bmax_d;
  logic [lcrv_pkg::FREQ_W-1:0]   rmin_q, rmin_d, rmax_q, rmax_d, mmin_q, mmin_d;
  logic [lcrv_pkg::BASE_W-1:0]   base_q, base_d;
  logic                          bvld_q, bvld_d, cal_q, cal_d;
  logic [31:0]                   tank_q, tank_d;
  logic [63:0]                   x_q, x_d, t_q, t_d, u_q, u_d;
  logic [63:0]                   opa_q, opa_d, opb_q, opb_d;
  logic [63:0]                   r_q, r_d, lo_q, lo_d, qt_q, qt_d;
  logic [127:0]                  acc_q, acc_d;
  logic                          ov_q, ov_d;
  logic [31:0]                   oval_q, oval_d;
  logic [lcrv_pkg::SCL_W-1:0]    oscl_q, oscl_d;
  logic [lcrv_pkg::STAT_W-1:0]   ost_q, ost_d;

  lcrv_pkg::uop_t                uop;
  logic [63:0]                   src_a, src_b, rsh, mul_res, wb_res, post_res, rnd_s, rnd_h;
  logic [31:0]                   rnd;
  logic                          ge, cond_ok;
  logic [31:0]                   pa, pb;
  logic [63:0]                   pp;
  logic [1:0]                    pp_sh;
  logic [lcrv_pkg::FREQ_W-1:0]   fe;
  logic [lcrv_pkg::FREQ_W-1:0]   base_ext;

  function automatic logic [63:0] src_sel(input lcrv_pkg::uop_src_e s, input logic [63:0] t,
                                          input logic [63:0] u, input logic [63:0] x,
                                          input logic [lcrv_pkg::FREQ_W-1:0] fb,
                                          input logic [lcrv_pkg::FREQ_W-1:0] f,
                                          input logic [31:0] refc, input logic [31:0] tank);
    logic [63:0] v;
    v = t;
    case (s)
      lcrv_pkg::SRC_T:     v = t;
      lcrv_pkg::SRC_U:     v = u;
      lcrv_pkg::SRC_X:     v = x;
      lcrv_pkg::SRC_IFB:   v = fx_int(32'(fb));
      lcrv_pkg::SRC_IF:    v = fx_int(32'(f));
      lcrv_pkg::SRC_I1:    v = fx_int(32'd1);
      lcrv_pkg::SRC_I10:   v = fx_int(32'd10);
      lcrv_pkg::SRC_I1K:   v = fx_int(32'd1000);
      lcrv_pkg::SRC_I10K:  v = fx_int(32'd10000);
      lcrv_pkg::SRC_I100K: v = fx_int(32'd100000);
      lcrv_pkg::SRC_I1M:   v = fx_int(32'd1000000);
      lcrv_pkg::SRC_IREF:  v = fx_int(refc);
      lcrv_pkg::SRC_ITANK: v = fx_int(tank);
      lcrv_pkg::SRC_FPS:   v = FPS;
      default:             v = t;
    endcase
    return v;
  endfunction

  assign in_i.ready       = (st_q == ST_IDLE);
  assign cfg_i.ready      = 1'b1;
  assign res_o.valid      = ov_q;
  assign res_o.value      = oval_q;
  assign res_o.scale_code = oscl_q;
  assign res_o.status     = ost_q;

  always_comb begin
    base_ext = lcrv_pkg::FREQ_W'(base_q);
    uop   = lcrv_pkg::decode(pc_q);
    src_a = src_sel(uop.sa, t_q, u_q, x_q, base_ext, f_q, 32'(refc_q), tank_q);
    src_b = src_sel(uop.sb, t_q, u_q, x_q, base_ext, f_q, 32'(refc_q), tank_q);
    // serial divider step
    rsh = {r_q[62:0], lo_q[63]};
    ge  = r_q[63] || (rsh >= opb_q);
    // multiplier partial product
    pa    = cnt_q[1] ? opa_q[63:32] : opa_q[31:0];
    pb    = cnt_q[0] ? opb_q[63:32] : opb_q[31:0];
    pp    = {32'd0, pa} * {32'd0, pb};
    pp_sh = 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
    mul_res = ((acc_q >> (64 + FRAC_BITS)) != '0) ? FX_MAX : acc_q[FRAC_BITS +: 64];
    wb_res  = (uop.kind == lcrv_pkg::UOP_DIV) ? qt_q : mul_res;
    case (uop.post)
      lcrv_pkg::POST_SUB1: post_res = (wb_res > ONE) ? wb_res - ONE : '0;
      lcrv_pkg::POST_SUBU: post_res = (u_q > wb_res) ? u_q - wb_res : '0;
      default:             post_res = wb_res;
    endcase
    case (uop.cond)
      lcrv_pkg::COND_LT10K: cond_ok = x_q < LIM10K;
      lcrv_pkg::COND_LT1K:  cond_ok = x_q < LIM1K;
      default:              cond_ok = 1'b1;
    endcase
    rnd_s = (x_q > FX_MAX - HALF) ? FX_MAX : x_q + HALF;
    rnd_h = rnd_s >> FRAC_BITS;
    rnd   = (rnd_h[63:32] != '0) ? '1 : rnd_h[31:0];
    fe    = ((in_i.opcode == lcrv_pkg::OP_IND) && (in_i.freq <= 23'd10)) ? base_ext : in_i.freq;

    st_d = st_q; pc_d = pc_q; cnt_d = cnt_q; op_d = op_q; f_d = f_q; stat_d = stat_q;
    small_d = small_q; refc_d = refc_q; bmin_d = bmin_q; bmax_d = bmax_q;
    rmin_d = rmin_q; rmax_d = rmax_q; mmin_d = mmin_q; base_d = base_q;
    bvld_d = bvld_q; cal_d = cal_q; tank_d = tank_q; x_d = x_q; t_d = t_q; u_d = u_q;
    opa_d = opa_q; opb_d = opb_q; r_d = r_q; lo_d = lo_q; qt_d = qt_q; acc_d = acc_q;
    ov_d = ov_q && !res_o.ready; oval_d = oval_q; oscl_d = oscl_q; ost_d = ost_q;

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lcrv_pkg::REG_REF_CAP:  refc_d = cfg_i.data[lcrv_pkg::REFC_W-1:0];
        lcrv_pkg::REG_BASE_MIN: bmin_d = cfg_i.data;
        lcrv_pkg::REG_BASE_MAX: bmax_d = cfg_i.data;
        lcrv_pkg::REG_REF_MIN:  rmin_d = cfg_i.data;
        lcrv_pkg::REG_REF_MAX:  rmax_d = cfg_i.data;
        lcrv_pkg::REG_MEAS_MIN: mmin_d = cfg_i.data;
        default: ;
      endcase
    end

    unique case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          op_d = in_i.opcode; f_d = fe; stat_d = lcrv_pkg::STAT_OK; small_d = 1'b0;
          st_d = ST_FIN;
          unique case (in_i.opcode)
            lcrv_pkg::OP_BASE: begin
              if (in_i.freq >= bmin_q && in_i.freq <= bmax_q &&
                  in_i.freq[lcrv_pkg::FREQ_W-1:lcrv_pkg::BASE_W] == '0) begin
                base_d = in_i.freq[lcrv_pkg::BASE_W-1:0];
                bvld_d = 1'b1;
              end else begin
                bvld_d = 1'b0;
                stat_d = lcrv_pkg::STAT_RANGE;
              end
              cal_d = 1'b0;
            end
            lcrv_pkg::OP_REF: begin
              if (!bvld_q) begin
                stat_d = lcrv_pkg::STAT_UNCAL;
              end else if (in_i.freq < rmin_q || in_i.freq > rmax_q) begin
                stat_d = lcrv_pkg::STAT_RANGE; cal_d = 1'b0;
              end else if (in_i.freq >= base_ext) begin
                stat_d = lcrv_pkg::STAT_ABOVE; cal_d = 1'b0;
              end else begin
                pc_d = lcrv_pkg::PC_REF; st_d = ST_ISSUE;
              end
            end
            default: begin
              if (!cal_q) begin
                stat_d = lcrv_pkg::STAT_UNCAL;
              end else if (in_i.freq > base_ext) begin
                stat_d = lcrv_pkg::STAT_ABOVE;
              end else if (fe < mmin_q) begin
                stat_d = lcrv_pkg::STAT_LOW;
              end else begin
                pc_d = (in_i.opcode == lcrv_pkg::OP_CAP) ? lcrv_pkg::PC_CAP : lcrv_pkg::PC_IND;
                st_d = ST_ISSUE;
              end
            end
          endcase
        end
      end
      ST_ISSUE: begin
        opa_d = src_a; opb_d = src_b;
        if (uop.kind == lcrv_pkg::UOP_END || !cond_ok) begin
          st_d = ST_FIN;
        end else begin
          if (uop.cond != lcrv_pkg::COND_NONE) small_d = 1'b1;
          if (uop.kind == lcrv_pkg::UOP_DIV) begin
            if (src_b == '0 || (src_a >> (64 - FRAC_BITS)) >= src_b) begin
              qt_d = FX_MAX; st_d = ST_WB;
            end else begin
              r_d = src_a >> (64 - FRAC_BITS); lo_d = src_a << FRAC_BITS;
              qt_d = '0; cnt_d = 6'd63; st_d = ST_DIV;
            end
          end else begin
            acc_d = '0; cnt_d = '0; st_d = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        r_d  = ge ? rsh - opb_q : rsh;
        lo_d = {lo_q[62:0], 1'b0};
        qt_d = {qt_q[62:0], ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          cnt_d = '0; st_d = ST_WB;
        end
      end
      ST_MUL: begin
        acc_d = acc_q + ({64'd0, pp} << {pp_sh, 5'd0});
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = '0; st_d = ST_WB;
        end
      end
      ST_WB: begin
        unique case (uop.dst)
          lcrv_pkg::DST_T: t_d = post_res;
          lcrv_pkg::DST_U: u_d = post_res;
          default:         x_d = post_res;
        endcase
        pc_d = pc_q + 5'd1;
        st_d = ST_ISSUE;
      end
      ST_FIN: begin
        if (!ov_q || res_o.ready) begin
          ov_d = 1'b1; ost_d = stat_q; oval_d = '0; oscl_d = lcrv_pkg::SCL_10FF;
          if (stat_q == lcrv_pkg::STAT_OK) begin
            unique case (op_q)
              lcrv_pkg::OP_BASE: ;
              lcrv_pkg::OP_REF: begin
                tank_d = rnd; cal_d = 1'b1; oval_d = rnd; oscl_d = lcrv_pkg::SCL_01PF;
              end
              lcrv_pkg::OP_CAP: begin
                oval_d = rnd; oscl_d = small_q ? lcrv_pkg::SCL_10FF : lcrv_pkg::SCL_01PF;
              end
              default: begin
                oval_d = rnd; oscl_d = small_q ? lcrv_pkg::SCL_NH : lcrv_pkg::SCL_UH;
              end
            endcase
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; pc_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
      refc_q <= 20'd10000; bmin_q <= 23'd550000; bmax_q <= 23'd650000;
      rmin_q <= 23'd400000; rmax_q <= 23'd440000; mmin_q <= 23'd10000;
      base_q <= '0; bvld_q <= 1'b0; cal_q <= 1'b0; tank_q <= '0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; cnt_q <= cnt_d; ov_q <= ov_d;
      refc_q <= refc_d; bmin_q <= bmin_d; bmax_q <= bmax_d;
      rmin_q <= rmin_d; rmax_q <= rmax_d; mmin_q <= mmin_d;
      base_q <= base_d; bvld_q <= bvld_d; cal_q <= cal_d; tank_q <= tank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; f_q <= f_d; stat_q <= stat_d; small_q <= small_d;
    x_q <= x_d; t_q <= t_d; u_q <= u_d; opa_q <= opa_d; opb_q <= opb_d;
    r_q <= r_d; lo_q <= lo_d; qt_q <= qt_d; acc_q <= acc_d;
    oval_q <= oval_d; oscl_q <= oscl_d; ost_q <= ost_d;
  end

  `LCRV_ASSERT(a_cal_needs_base, clk_i, rst_ni, (!cal_q || bvld_q), "calibrated without base")
  `LCRV_ASSERT(a_res_from_fin, clk_i, rst_ni,
               ($rose(ov_q) |-> $past(st_q) == ST_FIN), "beat not from finish")
  `LCRV_ASSERT(a_err_zero, clk_i, rst_ni,
               ((ov_q && ost_q != lcrv_pkg::STAT_OK) |->
                (oval_q == '0 && oscl_q == lcrv_pkg::SCL_10FF)), "error beat carries value")
endmodule
